// ===== src/todc_pkg.sv =====
// ---------------------------------------------------------------------------
// Time-of-day counter package
// Shared payload types, operation codes and time limits.
// ---------------------------------------------------------------------------
package todc_pkg;

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_SET  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [5:0] SECOND_MAX = 6'd59;
   localparam logic [5:0] MINUTE_MAX = 6'd59;
   localparam logic [4:0] HOUR_MAX   = 5'd23;

   typedef struct packed {
      logic [1:0]        operation;
      logic signed [7:0] set_hour;
      logic signed [7:0] set_minute;
      logic signed [7:0] set_second;
   } req_payload_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } rsp_payload_type;

endpackage

// ===== src/todc_normalize.sv =====
// ---------------------------------------------------------------------------
// Set-time normalizer
// Reduces signed hour/minute/second to a valid 24-hour time with floored
// carries and borrows. Pure combinational logic.
// ---------------------------------------------------------------------------
module todc_normalize
   import todc_pkg::*;
(
   input  logic signed [7:0] set_hour,
   input  logic signed [7:0] set_minute,
   input  logic signed [7:0] set_second,
   output rsp_payload_type   time_out
);

   // Operands are biased to be nonnegative; the bias is a multiple of the
   // divisor so the remainder is unchanged and the quotient is offset.
   logic [9:0] sec_biased;
   logic [9:0] min_biased;
   logic [9:0] hour_biased;
   logic [2:0] sec_quo;
   logic [2:0] min_quo;
   logic [3:0] hour_quo;
   logic [8:0] sec_rem;
   logic [8:0] min_rem;
   logic [8:0] hour_rem;

   // second + 180 : 52..307
   assign sec_biased = 10'({{2{set_second[7]}}, set_second}) + 10'd180;

   always_comb begin
      sec_quo = 3'd0;
      for (int k = 1; k <= 5; k++) begin
         if (sec_biased[8:0] >= 9'(k * 60)) begin
            sec_quo = 3'(k);
         end
      end
   end

   assign sec_rem = sec_biased[8:0] - 9'(sec_quo) * 9'd60;

   // minute + (sec_quo - 3) + 180 : 49..309
   assign min_biased = 10'({{2{set_minute[7]}}, set_minute}) + 10'(sec_quo) + 10'd177;

   always_comb begin
      min_quo = 3'd0;
      for (int k = 1; k <= 5; k++) begin
         if (min_biased[8:0] >= 9'(k * 60)) begin
            min_quo = 3'(k);
         end
      end
   end

   assign min_rem = min_biased[8:0] - 9'(min_quo) * 9'd60;

   // hour + (min_quo - 3) + 144 : 13..273
   assign hour_biased = 10'({{2{set_hour[7]}}, set_hour}) + 10'(min_quo) + 10'd141;

   always_comb begin
      hour_quo = 4'd0;
      for (int k = 1; k <= 11; k++) begin
         if (hour_biased[8:0] >= 9'(k * 24)) begin
            hour_quo = 4'(k);
         end
      end
   end

   assign hour_rem = hour_biased[8:0] - 9'(hour_quo) * 9'd24;

   assign time_out.hour   = hour_rem[4:0];
   assign time_out.minute = min_rem[5:0];
   assign time_out.second = sec_rem[5:0];

endmodule

// ===== src/todc_core.sv =====
// ---------------------------------------------------------------------------
// Time-of-day core
// Holds the current time and applies one tick, set or read per step.
// ---------------------------------------------------------------------------
module todc_core
   import todc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  req_payload_type item,
   output rsp_payload_type time_now
);

   rsp_payload_type time_ff;
   rsp_payload_type time_in;
   rsp_payload_type tick_time;
   rsp_payload_type set_time;

   todc_normalize u_normalize (
      .set_hour   (item.set_hour),
      .set_minute (item.set_minute),
      .set_second (item.set_second),
      .time_out   (set_time)
   );

   always_comb begin
      tick_time = time_ff;
      if (time_ff.second == SECOND_MAX) begin
         tick_time.second = 6'd0;
         if (time_ff.minute == MINUTE_MAX) begin
            tick_time.minute = 6'd0;
            tick_time.hour   = (time_ff.hour == HOUR_MAX) ? 5'd0 : time_ff.hour + 5'd1;
         end else begin
            tick_time.minute = time_ff.minute + 6'd1;
         end
      end else begin
         tick_time.second = time_ff.second + 6'd1;
      end
   end

   always_comb begin
      time_in = time_ff;
      if (step) begin
         case (item.operation)
            OP_TICK: time_in = tick_time;
            OP_SET:  time_in = set_time;
            OP_READ: time_in = time_ff;
            default: time_in = time_ff;   // unused code reads only
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
      end else begin
         time_ff <= time_in;
      end
   end

   assign time_now = time_ff;

endmodule

// ===== src/time_of_day_counter.sv =====
// ---------------------------------------------------------------------------
// Time-of-day counter
// 24-hour hh:mm:ss clock with tick, set and read transactions.
// ---------------------------------------------------------------------------
// One transaction is accepted per clock cycle while the input is not stalled.
// Each result is registered: the transaction waits in the input register,
// then the time register, which doubles as the result register, takes the
// updated time once the result side can advance. The input stalls only
// while both registers hold a transaction and the result is stalled. Every
// transaction returns the time after its step. The set path normalizes
// signed fields with floored carries in a single pass of compare logic.
module time_of_day_counter
   import todc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic            stage_valid_ff;
   logic            stage_valid_in;
   req_payload_type stage_item_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            advance;
   logic            step;
   logic            req_take;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = stage_valid_ff && advance;
   assign req_stall = stage_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign stage_valid_in = req_take || (stage_valid_ff && !advance);
   assign rsp_valid_in   = step || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_item_ff <= req_payload;
      end
   end

   todc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .item     (stage_item_ff),
      .time_now (rsp_payload)
   );

   assign rsp_valid = rsp_valid_ff;

   // Time always stays a legal 24-hour value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_payload.hour <= HOUR_MAX && rsp_payload.minute <= MINUTE_MAX &&
      rsp_payload.second <= SECOND_MAX)
      else $error("time out of range");

   // A held result must not see the time move underneath it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(rsp_payload))
      else $error("time changed while result stalled");

   // Every processed item produces a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("processed item lost its result");

   // A stalled input stage keeps its item.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |=> stage_valid_ff)
      else $error("stalled item dropped");

   // A tick mid-minute advances only the second.
   assert property (@(posedge clock) disable iff (reset)
      step && stage_item_ff.operation == OP_TICK && rsp_payload.second != SECOND_MAX
      |=> rsp_payload.second == $past(rsp_payload.second) + 6'd1 &&
          rsp_payload.minute == $past(rsp_payload.minute))
      else $error("tick did not advance second");

endmodule

// ===== bench/todc_checker.sv =====
// ---------------------------------------------------------------------------
// Time-of-day counter checker
// Watches both channels, keeps its own hh:mm:ss copy, and compares results.
// ---------------------------------------------------------------------------
module todc_checker
   import todc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  rsp_payload_type rsp_payload,
   output int              failures,
   output int              pending,
   output int              checked
);

   localparam int SECONDS_PER_MINUTE = 60;
   localparam int MINUTES_PER_HOUR   = 60;
   localparam int HOURS_PER_DAY      = 24;

   logic [4:0]      hour_now;
   logic [5:0]      minute_now;
   logic [5:0]      second_now;
   rsp_payload_type expected_times[$];
   rsp_payload_type want;

   task automatic report(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      failures++;
   endtask

   // floored remainder in 0..b-1, floored quotient out through quot
   function automatic int floor_mod(input int a, input int b, output int quot);
      int r;
      r    = a % b;
      quot = a / b;
      if (r < 0) begin
         r    += b;
         quot -= 1;
      end
      return r;
   endfunction

   function automatic rsp_payload_type advance_time(input req_payload_type r);
      int              s;
      int              m;
      int              h;
      int              carry;
      rsp_payload_type t;
      case (r.operation)
         OP_TICK: begin
            if (second_now == SECOND_MAX) begin
               second_now = '0;
               if (minute_now == MINUTE_MAX) begin
                  minute_now = '0;
                  hour_now   = (hour_now == HOUR_MAX) ? '0 : hour_now + 5'd1;
               end else begin
                  minute_now = minute_now + 6'd1;
               end
            end else begin
               second_now = second_now + 6'd1;
            end
         end
         OP_SET: begin
            s = floor_mod($signed(r.set_second), SECONDS_PER_MINUTE, carry);
            m = floor_mod($signed(r.set_minute) + carry, MINUTES_PER_HOUR, carry);
            h = floor_mod($signed(r.set_hour) + carry, HOURS_PER_DAY, carry);
            hour_now   = h[4:0];
            minute_now = m[5:0];
            second_now = s[5:0];
         end
         default: ;  // read, and the spare code behaves as a read
      endcase
      t.hour   = hour_now;
      t.minute = minute_now;
      t.second = second_now;
      return t;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         hour_now   = '0;
         minute_now = '0;
         second_now = '0;
         expected_times.delete();
         pending    = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_times.size() == 0) begin
               report($sformatf("result %0d:%0d:%0d with no transaction outstanding",
                                rsp_payload.hour, rsp_payload.minute, rsp_payload.second));
            end else begin
               want = expected_times.pop_front();
               checked++;
               if (rsp_payload.hour !== want.hour)
                  report($sformatf("hour got %0d expected %0d",
                                   rsp_payload.hour, want.hour));
               if (rsp_payload.minute !== want.minute)
                  report($sformatf("minute got %0d expected %0d",
                                   rsp_payload.minute, want.minute));
               if (rsp_payload.second !== want.second)
                  report($sformatf("second got %0d expected %0d",
                                   rsp_payload.second, want.second));
            end
         end
         if (req_valid && !req_stall)
            expected_times.push_back(advance_time(req_payload));
         pending = expected_times.size();
      end
   end

endmodule

// ===== bench/tb.sv =====
// ---------------------------------------------------------------------------
// Time-of-day counter testbench
// Directed carry/borrow cases, then bursty random traffic with result stalls.
// ---------------------------------------------------------------------------
module tb;
   import todc_pkg::*;

   localparam logic [1:0] OP_SPARE     = 2'd3;
   localparam int         RANDOM_ITEMS = 450;
   localparam int         DRAIN_EVERY  = 150;
   localparam int         CYCLE_LIMIT  = 200_000;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_MOSTLY, STALL_BURST} stall_mode_type;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;

   int             failures;
   int             pending;
   int             checked;
   int             cycles;
   int             tick_count;
   int             set_count;
   int             read_count;
   int             spare_count;
   int             random_sent;
   int             next_drain;
   int             pick;
   logic [1:0]     op;
   stall_mode_type stall_mode;
   int             stall_phase;

   time_of_day_counter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   todc_checker time_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .failures    (failures),
      .pending     (pending),
      .checked     (checked)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
         $display("TEST FAILED");
         $finish;
      end
   end

   // result-side stalls: the mode is redrawn at random from four patterns
   always @(negedge clock) begin
      if (stall_phase % 48 == 0)
         stall_mode = stall_mode_type'($urandom_range(0, 3));
      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_RANDOM: rsp_stall <= 1'($urandom_range(0, 1));
         STALL_MOSTLY: rsp_stall <= (stall_phase % 4) != 0;
         default:      rsp_stall <= (stall_phase % 16) < 10;
      endcase
      stall_phase++;
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input logic [1:0] code, input logic [7:0] h,
                               input logic [7:0] m, input logic [7:0] s);
      req_payload_type p;
      p.operation  = code;
      p.set_hour   = h;
      p.set_minute = m;
      p.set_second = s;
      req_valid   <= 1'b1;
      req_payload <= p;
      case (code)
         OP_TICK: tick_count++;
         OP_SET:  set_count++;
         OP_READ: read_count++;
         default: spare_count++;
      endcase
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic hold_off(input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   // half full-range noise, some in-range values, some edge values, some small negatives
   function automatic logic [7:0] pick_field(input int top);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return 8'($urandom_range(0, 255));
         5, 6, 7:       return 8'($urandom_range(0, top));
         8: begin
            case ($urandom_range(0, 5))
               0:       return 8'(top);
               1:       return 8'(top + 1);
               2:       return 8'h00;
               3:       return 8'hFF;
               4:       return 8'h7F;
               default: return 8'h80;
            endcase
         end
         default:       return 8'(-$urandom_range(1, top + 1));
      endcase
   endfunction

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_stall   = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: wraps, carries, borrows, ignored fields, spare code
      send_request(OP_READ,  8'h00, 8'h00, 8'h00);
      send_request(OP_TICK,  8'h80, 8'h7F, 8'hFF);
      send_request(OP_SPARE, 8'h05, 8'h05, 8'h05);
      send_request(OP_SET,   8'd23, 8'd59, 8'd59);
      send_request(OP_TICK,  8'h00, 8'h00, 8'h00);
      send_request(OP_SET,   8'd0,  8'd59, 8'd59);
      send_request(OP_TICK,  8'h00, 8'h00, 8'h00);
      send_request(OP_SET,   8'd12, 8'd34, 8'd59);
      send_request(OP_TICK,  8'h00, 8'h00, 8'h00);
      send_request(OP_SET,   8'd0,  8'd0,  8'hFF);
      send_request(OP_SET,   8'hFF, 8'hFF, 8'hFF);
      send_request(OP_SET,   8'h80, 8'h80, 8'h80);
      send_request(OP_SET,   8'h7F, 8'h7F, 8'h7F);
      send_request(OP_SET,   8'd24, 8'd60, 8'd60);
      send_request(OP_SET,   8'd0,  8'd0,  8'd60);
      send_request(OP_SET,   8'd0,  8'd59, 8'd60);
      send_request(OP_SET,   8'd23, 8'd59, 8'd60);
      send_request(OP_SET,   8'h7F, 8'h80, 8'h7F);
      send_request(OP_SET,   8'h80, 8'h7F, 8'h80);
      send_request(OP_READ,  8'h55, 8'hAA, 8'h55);
      send_request(OP_SPARE, 8'hFF, 8'hFF, 8'hFF);
      send_request(OP_TICK,  8'hAA, 8'h55, 8'hAA);
      send_request(OP_TICK,  8'h00, 8'h00, 8'h00);
      drain();

      next_drain = DRAIN_EVERY;
      while (random_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) begin
            // park near a rollover, then tick through it
            send_request(OP_SET, $urandom_range(0, 1) ? 8'd23 : 8'($urandom_range(0, 23)),
                         8'd59, 8'($urandom_range(55, 59)));
            repeat (6)
               send_request(OP_TICK, pick_field(HOUR_MAX), pick_field(MINUTE_MAX),
                            pick_field(SECOND_MAX));
            random_sent += 7;
         end else begin
            repeat ($urandom_range(1, 12)) begin
               pick = $urandom_range(0, 19);
               if (pick < 9)       op = OP_TICK;
               else if (pick < 14) op = OP_SET;
               else if (pick < 18) op = OP_READ;
               else                op = OP_SPARE;
               send_request(op, pick_field(HOUR_MAX), pick_field(MINUTE_MAX),
                            pick_field(SECOND_MAX));
               random_sent++;
            end
         end
         if (random_sent >= next_drain) begin
            drain();
            next_drain += DRAIN_EVERY;
         end else begin
            hold_off(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
         end
      end

      drain();
      repeat (4) @(negedge clock);
      $display("Sent %0d ticks, %0d sets, %0d reads, %0d spare-code reads; %0d results compared.",
               tick_count, set_count, read_count, spare_count, checked);
      $display("Sets used the full signed field range; results saw four stall patterns.");
      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
src/todc_pkg.sv
src/todc_normalize.sv
src/todc_core.sv
src/time_of_day_counter.sv
bench/todc_checker.sv
bench/tb.sv
